[hw/rtl/rleb_pkg.sv]
package rleb_pkg;

  // Default source image size.
  localparam int ImageWidthDef  = 640;
  localparam int ImageHeightDef = 480;

  // Field widths.
  localparam int RunW   = 15;
  localparam int ColourW = 16;
  localparam int CoordW = 12;
  localparam int PitchW = 16;
  localparam int MagW   = 2;
  localparam int OffW   = 28;
  localparam int WordW  = 24;
  localparam int CfgDataW = 16;
  localparam int CfgIdxW  = 3;

  // At most this many rectangles leave for one run.
  localparam int MaxResults = 53;
  localparam int CntW = $clog2(MaxResults + 1);

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegScreenWidth  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegScreenHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLinePitch    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegWidePixels   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMagnify      = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [CoordW-1:0] ScreenWidthRst  = 12'd640;
  localparam logic [CoordW-1:0] ScreenHeightRst = 12'd480;
  localparam logic [PitchW-1:0] LinePitchRst    = 16'd1280;
  localparam logic              WidePixelsRst   = 1'b0;
  localparam logic [MagW-1:0]   MagnifyRst      = 2'd1;

  typedef struct packed {
    logic [CoordW-1:0] screen_width;
    logic [CoordW-1:0] screen_height;
    logic [PitchW-1:0] line_pitch;
    logic              wide_pixels;
    logic [MagW-1:0]   magnify;
  } rleb_cfg_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;   // take a new run
    logic step;   // cut one piece off the run
    logic mul;    // form the byte offset of the captured piece
    logic push;   // move the piece into the output register
  } rleb_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic run_empty;  // nothing left of the run, or image finished
    logic emit;       // the next piece produces a rectangle
    logic out_free;   // output register can take an item this cycle
  } rleb_sts_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_MUL,
    ST_PUSH
  } rleb_state_t;

  // RGB565 as is, or widened to 8-bit channels by bit replication.
  function automatic logic [WordW-1:0] make_word(input logic [ColourW-1:0] c,
                                                 input logic wide);
    logic [4:0] r5;
    logic [5:0] g6;
    logic [4:0] b5;
    r5 = c[15:11];
    g6 = c[10:5];
    b5 = c[4:0];
    if (wide) begin
      make_word = {r5, r5[4:2], g6, g6[5:4], b5, b5[4:2]};
    end else begin
      make_word = {8'h00, c};
    end
  endfunction

endpackage

[hw/rtl/rle_image_scaled_blitter_core.sv]
// A run is taken in ST_IDLE; each rectangle then passes the piece cut (ST_STEP), the offset
// multiply (ST_MUL) and the output load (ST_PUSH), which waits while the output register
// is full and stalled; a piece that yields no rectangle is only cut, and a new run is
// taken only once the current one is used up.
// Reset is synchronous, active low: configuration returns to its defaults and the
// source position to the image origin; the output register is emptied.
module rle_image_scaled_blitter_core #(
  parameter int IMAGE_WIDTH  = rleb_pkg::ImageWidthDef,
  parameter int IMAGE_HEIGHT = rleb_pkg::ImageHeightDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rleb_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [rleb_pkg::CfgDataW-1:0] cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rleb_pkg::RunW-1:0]     in_run_length,
  input  logic [rleb_pkg::ColourW-1:0]  in_run_colour,
  input  logic                          in_image_start,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rleb_pkg::CoordW-1:0]   out_rect_x,
  output logic [rleb_pkg::CoordW-1:0]   out_rect_y,
  output logic [rleb_pkg::CoordW-1:0]   out_rect_w,
  output logic [rleb_pkg::MagW-1:0]     out_rect_h,
  output logic [rleb_pkg::OffW-1:0]     out_byte_offset,
  output logic [rleb_pkg::WordW-1:0]    out_pixel_word,
  output logic                          out_run_done
);
  import rleb_pkg::*;

  rleb_cfg_t cfg_r;
  rleb_cmd_t cmd;
  rleb_sts_t sts;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_width  <= ScreenWidthRst;
      cfg_r.screen_height <= ScreenHeightRst;
      cfg_r.line_pitch    <= LinePitchRst;
      cfg_r.wide_pixels   <= WidePixelsRst;
      cfg_r.magnify       <= MagnifyRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegScreenWidth:  cfg_r.screen_width  <= cfg_wdata[CoordW-1:0];
        RegScreenHeight: cfg_r.screen_height <= cfg_wdata[CoordW-1:0];
        RegLinePitch:    cfg_r.line_pitch    <= cfg_wdata[PitchW-1:0];
        RegWidePixels:   cfg_r.wide_pixels   <= cfg_wdata[0];
        RegMagnify:      cfg_r.magnify       <= cfg_wdata[MagW-1:0];
        default: begin
        end
      endcase
    end
  end

  rleb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  rleb_dp #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .cmd             (cmd),
    .sts             (sts),
    .in_run_length   (in_run_length),
    .in_run_colour   (in_run_colour),
    .in_image_start  (in_image_start),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_rect_x      (out_rect_x),
    .out_rect_y      (out_rect_y),
    .out_rect_w      (out_rect_w),
    .out_rect_h      (out_rect_h),
    .out_byte_offset (out_byte_offset),
    .out_pixel_word  (out_pixel_word),
    .out_run_done    (out_run_done)
  );

  // A new item is only taken once the previous run is used up.
  a_accept_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> sts.run_empty)
    else $error("item accepted while a run is still in progress");

  // An output item only appears after a load of the output register.
  a_out_from_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.push))
    else $error("output valid rose without a load");

  // The offset is only formed for a piece that was captured.
  a_mul_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul |-> $past(cmd.step && sts.emit))
    else $error("offset formed without a captured piece");

  // The output register is never overwritten while it still holds an item.
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> sts.out_free)
    else $error("output register overwritten");

endmodule

[hw/rtl/rleb_ctrl.sv]
module rleb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  rleb_pkg::rleb_sts_t sts,
  output rleb_pkg::rleb_cmd_t cmd,
  output logic              in_stall
);
  import rleb_pkg::*;

  rleb_state_t state_r;
  rleb_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        if (sts.run_empty) begin
          state_nxt = ST_IDLE;
        end else if (sts.emit) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        if (sts.out_free) begin
          state_nxt = ST_STEP;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_STEP: begin
        cmd.step = !sts.run_empty;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
      end
      ST_PUSH: begin
        cmd.push = sts.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

[hw/rtl/rleb_dp.sv]
module rleb_dp #(
  parameter int IMAGE_WIDTH  = rleb_pkg::ImageWidthDef,
  parameter int IMAGE_HEIGHT = rleb_pkg::ImageHeightDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rleb_pkg::rleb_cfg_t           cfg,
  input  rleb_pkg::rleb_cmd_t           cmd,
  output rleb_pkg::rleb_sts_t           sts,
  input  logic [rleb_pkg::RunW-1:0]     in_run_length,
  input  logic [rleb_pkg::ColourW-1:0]  in_run_colour,
  input  logic                          in_image_start,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [rleb_pkg::CoordW-1:0]   out_rect_x,
  output logic [rleb_pkg::CoordW-1:0]   out_rect_y,
  output logic [rleb_pkg::CoordW-1:0]   out_rect_w,
  output logic [rleb_pkg::MagW-1:0]     out_rect_h,
  output logic [rleb_pkg::OffW-1:0]     out_byte_offset,
  output logic [rleb_pkg::WordW-1:0]    out_pixel_word,
  output logic                          out_run_done
);
  import rleb_pkg::*;

  localparam int ColW  = $clog2(IMAGE_WIDTH);
  localparam int SpanW = $clog2(IMAGE_WIDTH + 1);
  localparam int RowW  = $clog2(IMAGE_HEIGHT);
  localparam int RincW = $clog2(IMAGE_HEIGHT + 1);

  // Source position and run state.
  logic [ColW-1:0]  col_r;
  logic [RowW-1:0]  row_r;
  logic             over_r;
  logic [RunW-1:0]  remain_r;
  logic [CntW-1:0]  cnt_r;
  logic [WordW-1:0] word_r;

  // Captured piece.
  logic [CoordW-1:0] cur_x_r;
  logic [CoordW-1:0] cur_y_r;
  logic [CoordW-1:0] cur_w_r;
  logic [MagW-1:0]   cur_h_r;
  logic              cur_done_r;
  logic [OffW-1:0]   cur_off_r;

  // Output register.
  logic              out_valid_r;
  logic [CoordW-1:0] out_x_r;
  logic [CoordW-1:0] out_y_r;
  logic [CoordW-1:0] out_w_r;
  logic [MagW-1:0]   out_h_r;
  logic [OffW-1:0]   out_off_r;
  logic [WordW-1:0]  out_word_r;
  logic              out_done_r;

  logic [MagW-1:0]   mag;
  logic [CoordW-1:0] dst_w;
  logic [CoordW-1:0] dst_h;
  logic              fits;
  logic [CoordW-1:0] org_x;
  logic [CoordW-1:0] org_y;

  logic [SpanW-1:0]  span_full;
  logic [SpanW-1:0]  span;
  logic [SpanW-1:0]  col_sum;
  logic              wrap;
  logic [RincW-1:0]  row_inc;
  logic              over_set;
  logic [RunW-1:0]   remain_after;
  logic [CoordW-1:0] piece_x;
  logic [CoordW-1:0] piece_y;
  logic [CoordW-1:0] piece_w;
  logic              piece_done;
  logic [OffW-1:0]   line_off;
  logic [OffW-1:0]   col_off;

  // Placement of the magnified image; a zero magnification counts as one.
  always_comb begin
    mag   = (cfg.magnify == '0) ? MagW'(1) : cfg.magnify;
    dst_w = CoordW'(IMAGE_WIDTH) * CoordW'(mag);
    dst_h = CoordW'(IMAGE_HEIGHT) * CoordW'(mag);
    fits  = (cfg.screen_width >= dst_w) && (cfg.screen_height >= dst_h);
    org_x = (cfg.screen_width - dst_w) >> 1;
    org_y = (cfg.screen_height - dst_h) >> 1;
  end

  // Cut the next piece: the rest of the source row or the rest of the run.
  // When the image fits, every piece lies fully on screen, so no clipping
  // is left to do.
  always_comb begin
    span_full = SpanW'(IMAGE_WIDTH) - SpanW'(col_r);
    if (RunW'(span_full) > remain_r) begin
      span = SpanW'(remain_r);
    end else begin
      span = span_full;
    end
    col_sum      = SpanW'(col_r) + span;
    wrap         = (col_sum == SpanW'(IMAGE_WIDTH));
    row_inc      = RincW'(row_r) + RincW'(1);
    over_set     = wrap && (row_inc == RincW'(IMAGE_HEIGHT));
    remain_after = remain_r - RunW'(span);
    piece_x      = org_x + CoordW'(col_r) * CoordW'(mag);
    piece_y      = org_y + CoordW'(row_r) * CoordW'(mag);
    piece_w      = CoordW'(span) * CoordW'(mag);
    piece_done   = (remain_after == '0) || over_set || (cnt_r == CntW'(MaxResults - 1));
  end

  assign sts.run_empty = (remain_r == '0) || over_r;
  assign sts.emit      = fits && (cnt_r < CntW'(MaxResults));
  assign sts.out_free  = !out_valid_r || !out_stall;

  // Run state and source position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      over_r   <= 1'b0;
      remain_r <= '0;
      cnt_r    <= '0;
    end else if (cmd.load) begin
      remain_r <= in_run_length;
      cnt_r    <= '0;
      if (in_image_start) begin
        col_r  <= '0;
        row_r  <= '0;
        over_r <= 1'b0;
      end
    end else if (cmd.step) begin
      remain_r <= remain_after;
      if (sts.emit) begin
        cnt_r <= cnt_r + CntW'(1);
      end
      if (wrap) begin
        col_r <= '0;
        if (over_set) begin
          row_r  <= '0;
          over_r <= 1'b1;
        end else begin
          row_r <= RowW'(row_inc);
        end
      end else begin
        col_r <= ColW'(col_sum);
      end
    end
  end

  // Pixel word of the run.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word_r <= make_word(in_run_colour, cfg.wide_pixels);
    end
  end

  // Capture the piece, then form its byte offset.
  assign line_off = OffW'(cur_y_r) * OffW'(cfg.line_pitch);
  assign col_off  = cfg.wide_pixels ? (OffW'(cur_x_r) << 2) : (OffW'(cur_x_r) << 1);

  always_ff @(posedge clk) begin
    if (cmd.step && sts.emit) begin
      cur_x_r    <= piece_x;
      cur_y_r    <= piece_y;
      cur_w_r    <= piece_w;
      cur_h_r    <= mag;
      cur_done_r <= piece_done;
    end
    if (cmd.mul) begin
      cur_off_r <= line_off + col_off;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_x_r    <= cur_x_r;
      out_y_r    <= cur_y_r;
      out_w_r    <= cur_w_r;
      out_h_r    <= cur_h_r;
      out_off_r  <= cur_off_r;
      out_word_r <= word_r;
      out_done_r <= cur_done_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_rect_x      = out_x_r;
  assign out_rect_y      = out_y_r;
  assign out_rect_w      = out_w_r;
  assign out_rect_h      = out_h_r;
  assign out_byte_offset = out_off_r;
  assign out_pixel_word  = out_word_r;
  assign out_run_done    = out_done_r;

endmodule

[tb/sv/tb_rle_image_scaled_blitter_core.sv]
module tb_rle_image_scaled_blitter_core;
  timeunit 1ns;
  timeprecision 1ps;

  import rleb_pkg::*;

  localparam int unsigned ImgW = ImageWidthDef;
  localparam int unsigned ImgH = ImageHeightDef;
  localparam int unsigned ImgPixels = ImgW * ImgH;
  // The settle time covers a run with no rectangles that still cuts dropped pieces.
  localparam int SettleCycles = 100;
  localparam int HoldCycles = 500;
  localparam int WatchdogLimit = 4000;

  typedef enum {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_t;

  typedef struct {
    logic [RunW-1:0]    len;
    logic [ColourW-1:0] colour;
    logic               restart;
  } run_t;

  typedef struct {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] w;
    logic [MagW-1:0]   h;
    logic [OffW-1:0]   off;
    logic [WordW-1:0]  word;
    logic              done;
  } rect_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;
  logic                in_valid;
  logic                in_stall;
  logic [RunW-1:0]     in_run_length;
  logic [ColourW-1:0]  in_run_colour;
  logic                in_image_start;
  logic                out_valid;
  logic                out_stall;
  logic [CoordW-1:0]   out_rect_x;
  logic [CoordW-1:0]   out_rect_y;
  logic [CoordW-1:0]   out_rect_w;
  logic [MagW-1:0]     out_rect_h;
  logic [OffW-1:0]     out_byte_offset;
  logic [WordW-1:0]    out_pixel_word;
  logic                out_run_done;

  // Runs waiting to be offered, and rectangles waiting to come out.
  run_t  run_q[$];
  rect_t rect_q[$];
  int    runs_queued = 0;
  int    runs_taken = 0;
  int    err_count = 0;
  int    quiet_cycles = 0;
  int unsigned gen_pos = 0;

  idle_mode_t idle_mode;
  logic       pressure_go;
  logic       hold_on;

  // Mirror of the configuration registers.
  int unsigned cfg_scr_w = 640;
  int unsigned cfg_scr_h = 480;
  int unsigned cfg_pitch = 1280;
  int unsigned cfg_wide = 0;
  int unsigned cfg_mag = 1;

  // Mirror of the source position.
  int unsigned src_col = 0;
  int unsigned src_row = 0;
  bit          img_over = 1'b0;

  rle_image_scaled_blitter_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_run_length  (in_run_length),
    .in_run_colour  (in_run_colour),
    .in_image_start (in_image_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_rect_x     (out_rect_x),
    .out_rect_y     (out_rect_y),
    .out_rect_w     (out_rect_w),
    .out_rect_h     (out_rect_h),
    .out_byte_offset(out_byte_offset),
    .out_pixel_word (out_pixel_word),
    .out_run_done   (out_run_done)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Framebuffer word for one colour at the current depth.
  function automatic logic [WordW-1:0] pixel_of(input logic [ColourW-1:0] c);
    logic [7:0] r8;
    logic [7:0] g8;
    logic [7:0] b8;
    r8 = {c[15:11], c[15:13]};
    g8 = {c[10:5], c[10:9]};
    b8 = {c[4:0], c[4:2]};
    if (cfg_wide == 0) begin
      return {8'h00, c};
    end
    return {r8, g8, b8};
  endfunction

  // Cut one run at source row ends and queue the rectangles it should produce.
  task automatic blit_run(input logic [RunW-1:0] len, input logic [ColourW-1:0] colour,
                          input logic restart);
    int unsigned left, m, ox, oy, bytes, span, x, y, w, h, n;
    longint unsigned off;
    bit fits, held;
    rect_t prev;
    left = len;
    n = 0;
    held = 1'b0;
    ox = 0;
    oy = 0;
    if (restart) begin
      src_col = 0;
      src_row = 0;
      img_over = 1'b0;
    end
    m = (cfg_mag == 0) ? 1 : cfg_mag;
    fits = cfg_scr_w >= ImgW * m && cfg_scr_h >= ImgH * m;
    if (fits) begin
      ox = (cfg_scr_w - ImgW * m) / 2;
      oy = (cfg_scr_h - ImgH * m) / 2;
    end
    bytes = cfg_wide ? 4 : 2;
    while (left > 0 && !img_over) begin
      span = ImgW - src_col;
      if (span > left) begin
        span = left;
      end
      if (fits && n < MaxResults) begin
        x = ox + src_col * m;
        y = oy + src_row * m;
        w = span * m;
        h = m;
        if (x < cfg_scr_w && y < cfg_scr_h) begin
          if (w > cfg_scr_w - x) begin
            w = cfg_scr_w - x;
          end
          if (h > cfg_scr_h - y) begin
            h = cfg_scr_h - y;
          end
          // The previous piece is not the last one, so it can go now.
          if (held) begin
            rect_q.push_back(prev);
          end
          off = longint'(y) * longint'(cfg_pitch) + longint'(x) * longint'(bytes);
          prev.x = x[CoordW-1:0];
          prev.y = y[CoordW-1:0];
          prev.w = w[CoordW-1:0];
          prev.h = h[MagW-1:0];
          prev.off = off[OffW-1:0];
          prev.word = pixel_of(colour);
          prev.done = 1'b0;
          held = 1'b1;
          n++;
        end
      end
      src_col += span;
      left -= span;
      if (src_col >= ImgW) begin
        src_col = 0;
        src_row++;
        if (src_row >= ImgH) begin
          src_row = 0;
          img_over = 1'b1;
        end
      end
    end
    if (held) begin
      prev.done = 1'b1;
      rect_q.push_back(prev);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_count++;
    end
  endtask

  // Input driver: offers queued runs, holds a stalled item steady.
  always @(posedge clk) begin : feed
    run_t nxt;
    int unsigned gap;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        blit_run(in_run_length, in_run_colour, in_image_start);
        runs_taken++;
      end
      if (!in_valid || !in_stall) begin
        gap = (idle_mode == IdleSender) ? 63 : (idle_mode == IdleBoth) ? 33 : 0;
        if (run_q.size() != 0 && $urandom_range(99) >= gap) begin
          nxt = run_q.pop_front();
          in_valid <= 1'b1;
          in_run_length <= nxt.len;
          in_run_colour <= nxt.colour;
          in_image_start <= nxt.restart;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: checks each accepted rectangle and drives the stall.
  always @(posedge clk) begin : sink
    rect_t want;
    int unsigned busy;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (rect_q.size() == 0) begin
          $error("rectangle at (%0d,%0d) arrived with none expected", out_rect_x, out_rect_y);
          err_count++;
        end else begin
          want = rect_q.pop_front();
          check_field("rect_x", want.x, out_rect_x);
          check_field("rect_y", want.y, out_rect_y);
          check_field("rect_w", want.w, out_rect_w);
          check_field("rect_h", want.h, out_rect_h);
          check_field("byte_offset", want.off, out_byte_offset);
          check_field("pixel_word", want.word, out_pixel_word);
          check_field("run_done", want.done, out_run_done);
        end
      end
      busy = (idle_mode == IdleReceiver) ? 63 : (idle_mode == IdleBoth) ? 33 : 0;
      out_stall <= hold_on || ($urandom_range(99) < busy);
    end
  end

  // Long receiver hold-off so the block backs up into its input.
  initial begin : hold_off
    hold_on = 1'b0;
    wait (pressure_go);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    hold_on <= 1'b0;
  end

  // Watchdog on cycles where neither side moves an item.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("tb_rle_image_scaled_blitter_core: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_run(input int unsigned len, input int unsigned colour, input bit restart);
    run_t r;
    r.len = len[RunW-1:0];
    r.colour = colour[ColourW-1:0];
    r.restart = restart;
    run_q.push_back(r);
    runs_queued++;
    if (restart) begin
      gen_pos = 0;
    end
    gen_pos += len;
  endtask

  // Random runs that mostly build whole images, with some early restarts.
  task automatic gen_runs(input int count);
    int unsigned pick, len;
    bit restart;
    for (int i = 0; i < count; i++) begin
      restart = 1'b0;
      if (gen_pos >= ImgPixels) begin
        restart = ($urandom_range(9) != 0);
      end else if ($urandom_range(99) < 2) begin
        restart = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 5) begin
        len = 0;
      end else if (pick < 60) begin
        len = $urandom_range(64, 1);
      end else if (pick < 88) begin
        len = $urandom_range(1280, 65);
      end else begin
        len = $urandom_range(32767, 1281);
      end
      queue_run(len, $urandom_range(65535), restart);
    end
  endtask

  // Waits for every run to be taken and every rectangle to arrive, then lets
  // the block finish any pieces that produce nothing.
  task automatic wait_idle();
    do @(posedge clk); while (runs_taken != runs_queued || rect_q.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CfgDataW-1:0];
    case (idx)
      RegScreenWidth: begin
        cfg_scr_w = val & 32'hfff;
      end
      RegScreenHeight: begin
        cfg_scr_h = val & 32'hfff;
      end
      RegLinePitch: begin
        cfg_pitch = val & 32'hffff;
      end
      RegWidePixels: begin
        cfg_wide = val & 32'h1;
      end
      RegMagnify: begin
        cfg_mag = val & 32'h3;
      end
      default: begin
      end
    endcase
  endtask

  task automatic start_phase(input int unsigned sw, input int unsigned sh,
                             input int unsigned pitch, input int unsigned wide,
                             input int unsigned mag, input idle_mode_t mode);
    wait_idle();
    write_reg(RegScreenWidth, sw);
    write_reg(RegScreenHeight, sh);
    write_reg(RegLinePitch, pitch);
    write_reg(RegWidePixels, wide);
    write_reg(RegMagnify, mag);
    @(posedge clk);
    cfg_we <= 1'b0;
    idle_mode = mode;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_run_length = '0;
    in_run_colour = '0;
    in_image_start = 1'b0;
    out_stall = 1'b0;
    pressure_go = 1'b0;
    idle_mode = IdleNone;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed runs on the reset configuration: an empty run, runs up to the last column, a run
    // from the last column that gives the most rectangles, running off the end
    // of the image, a dropped run, then a restart.
    queue_run(0, 16'hffff, 1'b1);
    queue_run(1, 16'h0000, 1'b0);
    queue_run(638, 16'hffff, 1'b0);
    queue_run(32767, 16'h7fff, 1'b0);
    queue_run(1, 16'h8000, 1'b0);
    for (int i = 0; i < 9; i++) begin
      queue_run(32767, 16'h07e0 ^ (i * 16'h1111), 1'b0);
    end
    queue_run(100, 16'h1234, 1'b0);
    queue_run(32767, 16'h0000, 1'b1);
    queue_run(5, 16'haaaa, 1'b0);
    queue_run(5, 16'h5555, 1'b0);

    // Largest screen and pitch, 32 bpp, three times magnified.
    start_phase(4095, 4095, 65535, 1, 3, IdleSender);
    queue_run(3, 16'h0000, 1'b1);
    queue_run(3, 16'hffff, 1'b0);
    queue_run(3, 16'hf800, 1'b0);
    queue_run(3, 16'h07e0, 1'b0);
    queue_run(3, 16'h001f, 1'b0);
    gen_runs(60);

    // Exact fit at twice the size.
    start_phase(1280, 960, 2560, 0, 2, IdleReceiver);
    gen_runs(60);

    // Screen too narrow: nothing comes out, the position still moves.
    start_phase(1, 4095, 1, 1, 1, IdleBoth);
    gen_runs(30);

    // Magnify zero acts as one; a pitch of one.
    start_phase(1000, 700, 1, 0, 0, IdleBoth);
    gen_runs(60);

    // Receiver holds off for a long stretch while runs keep coming.
    start_phase(2000, 1500, 4000, 1, 3, IdleNone);
    pressure_go = 1'b1;
    gen_runs(60);

    // Screen too low.
    start_phase(4095, 1, 65535, 0, 2, IdleSender);
    gen_runs(10);

    start_phase(640, 480, 1280, 0, 1, IdleReceiver);
    gen_runs(50);

    wait_idle();
    if (err_count == 0 && rect_q.size() == 0) begin
      $display("tb_rle_image_scaled_blitter_core: PASS");
    end else begin
      $display("tb_rle_image_scaled_blitter_core: FAIL");
    end
    $finish;
  end

endmodule
